### rtl/d96f_pkg.sv
// ----------------------------------------------------------------------------
// d96f_pkg
// Shared constants, tables, stage record and helpers for the scaled decimal
// to single-precision converter.
// ----------------------------------------------------------------------------
package d96f_pkg;

   localparam int MAX_SCALE = 28;
   localparam int MANT_W    = 96;
   localparam int REM_W     = MANT_W + 1;
   localparam int SIG_W     = 25;
   localparam int LZ_W      = 7;
   localparam int EXP_W     = 10;
   localparam int SCL_W     = 5;
   localparam int TAB_N     = 32;
   localparam int STEP_N    = SIG_W - 1;
   localparam int EXP_BIAS  = 127;

   typedef logic [MANT_W-1:0] pow_tab_type [TAB_N];
   typedef logic [LZ_W-1:0]   shf_tab_type [TAB_N];

   // record carried through the division stages
   typedef struct packed {
      logic                    vld;
      logic                    neg;
      logic                    bad;
      logic                    zero;
      logic [SCL_W-1:0]        scl;
      logic signed [EXP_W-1:0] expo;
      logic [REM_W-1:0]        rem;
      logic [SIG_W-1:0]        sig;
   } stage_type;

   // powers of ten shifted left until bit 95 is set
   function automatic pow_tab_type make_pow_tab();
      pow_tab_type  tab;
      logic [127:0] v;
      int           msb;
      for (int s = 0; s < TAB_N; s++) begin
         v = 128'd1;
         for (int k = 0; k < s && k < MAX_SCALE; k++) v = v * 128'd10;
         msb = 0;
         for (int b = 0; b < 128; b++) if (v[b]) msb = b;
         tab[s] = MANT_W'(v << (MANT_W - 1 - msb));
      end
      return tab;
   endfunction

   // shift used to normalise each power of ten
   function automatic shf_tab_type make_shf_tab();
      shf_tab_type  tab;
      logic [127:0] v;
      int           msb;
      for (int s = 0; s < TAB_N; s++) begin
         v = 128'd1;
         for (int k = 0; k < s && k < MAX_SCALE; k++) v = v * 128'd10;
         msb = 0;
         for (int b = 0; b < 128; b++) if (v[b]) msb = b;
         tab[s] = LZ_W'(MANT_W - 1 - msb);
      end
      return tab;
   endfunction

   localparam pow_tab_type POW10_NORM  = make_pow_tab();
   localparam shf_tab_type POW10_SHIFT = make_shf_tab();

   // leading zeros of one 32-bit word, 32 when empty
   function automatic logic [5:0] lzc32(input logic [31:0] w);
      logic [5:0] n;
      n = 6'd32;
      for (int b = 0; b < 32; b++) if (w[b]) n = 6'(31 - b);
      return n;
   endfunction

endpackage

### rtl/d96f_norm.sv
// ----------------------------------------------------------------------------
// d96f_norm
// Front end: leading zero count, mantissa normalisation and the first
// quotient bit against the normalised power of ten.
// ----------------------------------------------------------------------------
module d96f_norm (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  logic [31:0]         mantissa_low,
   input  logic [31:0]         mantissa_mid,
   input  logic [31:0]         mantissa_high,
   input  logic                negative,
   input  logic [7:0]          decimal_scale,
   output d96f_pkg::stage_type out_st
);
   import d96f_pkg::*;

   // stage a: capture and per-word zero counts
   logic              a_vld_ff, a_neg_ff, a_bad_ff, a_zero_ff;
   logic [SCL_W-1:0]  a_scl_ff;
   logic [MANT_W-1:0] a_m_ff;
   logic [5:0]        a_lzh_ff, a_lzm_ff, a_lzl_ff;
   logic              a_bad_in;

   assign a_bad_in = decimal_scale > 8'(MAX_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_vld;
      end
      if (en) begin
         a_neg_ff  <= negative;
         a_bad_ff  <= a_bad_in;
         a_zero_ff <= (mantissa_low == '0) && (mantissa_mid == '0) && (mantissa_high == '0);
         a_scl_ff  <= a_bad_in ? '0 : decimal_scale[SCL_W-1:0];
         a_m_ff    <= {mantissa_high, mantissa_mid, mantissa_low};
         a_lzh_ff  <= lzc32(mantissa_high);
         a_lzm_ff  <= lzc32(mantissa_mid);
         a_lzl_ff  <= lzc32(mantissa_low);
      end
   end

   // stage b: total count, shift and exponent
   logic                    b_vld_ff, b_neg_ff, b_bad_ff, b_zero_ff;
   logic [SCL_W-1:0]        b_scl_ff;
   logic signed [EXP_W-1:0] b_expo_ff, b_expo_in;
   logic [MANT_W-1:0]       b_mn_ff, b_mn_in;
   logic [LZ_W-1:0]         lz;

   always_comb begin
      if (a_lzh_ff != 6'd32) begin
         lz = LZ_W'(a_lzh_ff);
      end else if (a_lzm_ff != 6'd32) begin
         lz = LZ_W'(a_lzm_ff) + LZ_W'(32);
      end else begin
         lz = LZ_W'(a_lzl_ff) + LZ_W'(64);
      end
      b_mn_in   = a_m_ff << lz;
      b_expo_in = $signed({3'b000, POW10_SHIFT[a_scl_ff]}) - $signed({3'b000, lz});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
      if (en) begin
         b_neg_ff  <= a_neg_ff;
         b_bad_ff  <= a_bad_ff;
         b_zero_ff <= a_zero_ff;
         b_scl_ff  <= a_scl_ff;
         b_expo_ff <= b_expo_in;
         b_mn_ff   <= b_mn_in;
      end
   end

   // stage c: leading quotient bit, remainder in [0, divisor)
   stage_type         c_ff, c_in;
   logic [MANT_W-1:0] dv;

   always_comb begin
      dv        = POW10_NORM[b_scl_ff];
      c_in.vld  = b_vld_ff;
      c_in.neg  = b_neg_ff;
      c_in.bad  = b_bad_ff;
      c_in.zero = b_zero_ff;
      c_in.scl  = b_scl_ff;
      c_in.sig  = SIG_W'(1);
      if (b_mn_ff >= dv) begin
         c_in.rem  = {1'b0, b_mn_ff} - {1'b0, dv};
         c_in.expo = b_expo_ff;
      end else begin
         c_in.rem  = {b_mn_ff, 1'b0} - {1'b0, dv};
         c_in.expo = b_expo_ff - EXP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.vld <= 1'b0;
      end else if (en) begin
         c_ff.vld <= c_in.vld;
      end
      if (en) begin
         c_ff.neg  <= c_in.neg;
         c_ff.bad  <= c_in.bad;
         c_ff.zero <= c_in.zero;
         c_ff.scl  <= c_in.scl;
         c_ff.expo <= c_in.expo;
         c_ff.rem  <= c_in.rem;
         c_ff.sig  <= c_in.sig;
      end
   end

   assign out_st = c_ff;

endmodule

### rtl/d96f_step.sv
// ----------------------------------------------------------------------------
// d96f_step
// One restoring division stage: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module d96f_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  d96f_pkg::stage_type in_st,
   output d96f_pkg::stage_type out_st
);
   import d96f_pkg::*;

   stage_type        st_ff, st_in;
   logic [REM_W-1:0] r2, dv;

   // shift remainder, trial subtract
   always_comb begin
      st_in = in_st;
      r2    = {in_st.rem[REM_W-2:0], 1'b0};
      dv    = {1'b0, POW10_NORM[in_st.scl]};
      if (r2 >= dv) begin
         st_in.rem = r2 - dv;
         st_in.sig = {in_st.sig[SIG_W-2:0], 1'b1};
      end else begin
         st_in.rem = r2;
         st_in.sig = {in_st.sig[SIG_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.vld <= 1'b0;
      end else if (en) begin
         st_ff.vld <= st_in.vld;
      end
      if (en) begin
         st_ff.neg  <= st_in.neg;
         st_ff.bad  <= st_in.bad;
         st_ff.zero <= st_in.zero;
         st_ff.scl  <= st_in.scl;
         st_ff.expo <= st_in.expo;
         st_ff.rem  <= st_in.rem;
         st_ff.sig  <= st_in.sig;
      end
   end

   assign out_st = st_ff;

endmodule

### rtl/d96f_pack.sv
// ----------------------------------------------------------------------------
// d96f_pack
// Round to nearest even, assemble the single-precision word, output register.
// ----------------------------------------------------------------------------
module d96f_pack (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  d96f_pkg::stage_type in_st,
   output logic                out_vld,
   output logic [31:0]         float_bits,
   output logic                status
);
   import d96f_pkg::*;

   logic                    vld_ff, status_ff;
   logic [31:0]             bits_ff, bits_in;
   logic [SIG_W-1:0]        m25;
   logic                    rnd;
   logic [22:0]             frac;
   logic signed [EXP_W-1:0] expo, biased;

   // rounding and packing
   always_comb begin
      rnd = in_st.sig[0] && ((in_st.rem != '0) || in_st.sig[1]);
      m25 = {1'b0, in_st.sig[SIG_W-1:1]} + SIG_W'(rnd);
      if (m25[SIG_W-1]) begin
         frac = m25[23:1];
         expo = in_st.expo + EXP_W'(1);
      end else begin
         frac = m25[22:0];
         expo = in_st.expo;
      end
      biased = expo + EXP_W'(EXP_BIAS);
      if (in_st.bad || in_st.zero) begin
         bits_in = '0;
      end else begin
         bits_in = {in_st.neg, biased[7:0], frac};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_st.vld;
      end
      if (en) begin
         bits_ff   <= bits_in;
         status_ff <= in_st.bad;
      end
   end

   assign out_vld    = vld_ff;
   assign float_bits = bits_ff;
   assign status     = status_ff;

endmodule

### rtl/decimal96_to_float32.sv
// ----------------------------------------------------------------------------
// decimal96_to_float32
// Scaled 96-bit decimal to IEEE-754 single precision, round to nearest even.
// ----------------------------------------------------------------------------
// Converts (-1)^negative * mantissa / 10^decimal_scale into a single-precision
// bit pattern, rounded once to nearest even; a zero mantissa gives +0.0 and a
// scale above 28 gives status 1 with a zero result. The block takes one
// transfer per cycle while no result is held; each result passes through
// three front-end stages (zero count, normalise, first quotient bit), 24
// restoring division stages against a tabled normalised power of ten, and
// the rounding stage that also holds the result. A stall on the result side
// halts the whole pipeline; req_ready follows rsp_ready when a result waits.
module decimal96_to_float32 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_mantissa_low,
   input  logic [31:0] req_mantissa_mid,
   input  logic [31:0] req_mantissa_high,
   input  logic        req_negative,
   input  logic [7:0]  req_decimal_scale,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_float_bits,
   output logic        rsp_status
);
   import d96f_pkg::*;

   logic      en;
   stage_type st [STEP_N+1];

   // pipeline advances unless a result is held
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   d96f_norm u_norm (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_vld        (req_valid),
      .mantissa_low  (req_mantissa_low),
      .mantissa_mid  (req_mantissa_mid),
      .mantissa_high (req_mantissa_high),
      .negative      (req_negative),
      .decimal_scale (req_decimal_scale),
      .out_st        (st[0])
   );

   // quotient bit stages
   for (genvar g = 0; g < STEP_N; g++) begin : g_step
      d96f_step u_step (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .in_st  (st[g]),
         .out_st (st[g+1])
      );
   end

   d96f_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_st      (st[STEP_N]),
      .out_vld    (rsp_valid),
      .float_bits (rsp_float_bits),
      .status     (rsp_status)
   );

endmodule

### rtl/d96f_check.sv
// ----------------------------------------------------------------------------
// d96f_check
// Port-level checks on the converter, attached by bind.
// ----------------------------------------------------------------------------
module d96f_check (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_float_bits,
   input logic        rsp_status
);

   // held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_float_bits))
      else $error("result changed while stalled");

   // rejected scale gives zero
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_float_bits == 32'd0)
      else $error("rejected scale with nonzero result");

   // only zero has a zero exponent field
   a_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_float_bits[30:23] == 8'd0 |-> rsp_float_bits == 32'd0)
      else $error("subnormal or negative zero produced");

   // stalled output blocks new requests
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline stalled");

endmodule

bind decimal96_to_float32 d96f_check u_d96f_check (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_float_bits (rsp_float_bits),
   .rsp_status     (rsp_status)
);

### dv/d96f_checker.sv
// ----------------------------------------------------------------------------
// d96f_checker
// Watches both channels of the decimal converter, predicts each result from
// the accepted request and compares it with the next result transfer.
// ----------------------------------------------------------------------------
module d96f_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_mantissa_low,
   input  logic [31:0] req_mantissa_mid,
   input  logic [31:0] req_mantissa_high,
   input  logic        req_negative,
   input  logic [7:0]  req_decimal_scale,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_float_bits,
   input  logic        rsp_status,
   output int          fail_count,
   output int          pending_count
);

   localparam int    LIMIT_SCALE = 28;
   localparam int    FRAC_STEPS  = 140;
   localparam logic  STATUS_OK   = 1'b0;
   localparam logic  STATUS_BAD  = 1'b1;

   typedef struct {
      logic [31:0] bits;
      logic        status;
   } single_res_type;

   single_res_type float_queue[$];

   // exact long division of mantissa by a power of ten, rounded once
   function automatic single_res_type convert_decimal(input logic [95:0] mant,
                                                      input logic neg,
                                                      input logic [7:0] scale);
      single_res_type res;
      logic [191:0]   divisor;
      logic [191:0]   remainder;
      logic [24:0]    sig;
      logic [23:0]    frac;
      int             nbits;
      int             expo;
      logic           sticky;
      logic           qbit;
      res.bits   = '0;
      res.status = STATUS_OK;
      if (scale > LIMIT_SCALE) begin
         res.status = STATUS_BAD;
         return res;
      end
      if (mant == '0) return res;
      divisor = 192'd1;
      for (int i = 0; i < scale; i++) divisor = divisor * 192'd10;
      remainder = '0;
      sig       = '0;
      nbits     = 0;
      expo      = 0;
      sticky    = 1'b0;
      for (int pos = 95; pos >= -FRAC_STEPS; pos--) begin
         remainder = remainder << 1;
         if (pos >= 0) remainder[0] = mant[pos];
         qbit = remainder >= divisor;
         if (qbit) remainder = remainder - divisor;
         if (nbits == 0) begin
            if (qbit) begin
               expo  = pos;
               sig   = 25'd1;
               nbits = 1;
            end
         end else begin
            sig   = {sig[23:0], qbit};
            nbits = nbits + 1;
         end
         if (nbits == 25) begin
            sticky = remainder != '0;
            if (pos > 0) sticky = sticky || ((mant & ((96'd1 << pos) - 96'd1)) != '0);
            break;
         end
      end
      frac = sig[24:1];
      if (sig[0] && (sticky || frac[0])) frac = frac + 24'd1;
      // carry out of rounding gives 2^24 and wraps to zero
      if (frac == '0) expo = expo + 1;
      res.bits = {neg, 8'(expo + 127), frac[22:0]};
      return res;
   endfunction

   assign pending_count = float_queue.size();

   // request transfers become expectations, result transfers are checked
   always @(posedge clock) begin
      single_res_type want;
      if (reset) begin
         fail_count <= 0;
         float_queue.delete();
      end else begin
         if (req_valid && req_ready)
            float_queue.push_back(convert_decimal({req_mantissa_high, req_mantissa_mid,
               req_mantissa_low}, req_negative, req_decimal_scale));
         if (rsp_valid && rsp_ready) begin
            if (float_queue.size() == 0) begin
               $error("unexpected result transfer: float_bits %h", rsp_float_bits);
               fail_count <= fail_count + 1;
            end else begin
               want = float_queue.pop_front();
               if (rsp_float_bits !== want.bits) begin
                  $error("float_bits expected %h actual %h", want.bits, rsp_float_bits);
                  fail_count <= fail_count + 1;
               end else if (rsp_status !== want.status) begin
                  $error("status expected %b actual %b", want.status, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the decimal converter: directed corner cases, then
// random decimals with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_ITEMS = 1230;
   localparam int QUIET_ITEMS  = 200;
   localparam int WATCH_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_mantissa_low = '0;
   logic [31:0] req_mantissa_mid = '0;
   logic [31:0] req_mantissa_high = '0;
   logic        req_negative = 1'b0;
   logic [7:0]  req_decimal_scale = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_float_bits;
   logic        rsp_status;
   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;

   always #2 clock = ~clock;

   decimal96_to_float32 dut (.*);

   d96f_checker checker_i (.*);

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side stalls in bursts
   initial begin
      int n;
      @(posedge clock);
      while (1) begin
         rsp_ready <= 1'b1;
         n = $urandom_range(1, 30);
         repeat (n) @(posedge clock);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   // one request transfer, with an optional gap beforehand
   task automatic send_decimal(input logic [95:0] mant, input logic neg,
                               input logic [7:0] scale);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mantissa_low  <= mant[31:0];
      req_mantissa_mid  <= mant[63:32];
      req_mantissa_high <= mant[95:64];
      req_negative      <= neg;
      req_decimal_scale <= scale;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [95:0] rand_mant();
      logic [95:0] m;
      int          w;
      m = {$urandom, $urandom, $urandom};
      // vary magnitude so short and long quotients both appear
      w = $urandom_range(1, 96);
      if (w < 96) m = m & ((96'd1 << w) - 96'd1);
      return m;
   endfunction

   initial begin
      logic [95:0] m;
      logic [7:0]  s;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners
      send_decimal('0, 1'b1, 8'd0);
      send_decimal('0, 1'b0, 8'd29);
      send_decimal('1, 1'b1, 8'd255);
      send_decimal(96'd1, 1'b0, 8'd0);
      send_decimal(96'd1, 1'b1, 8'd28);
      send_decimal('1, 1'b0, 8'd0);
      send_decimal('1, 1'b1, 8'd28);
      send_decimal(96'd16777217, 1'b0, 8'd0);   // tie, rounds to even
      send_decimal(96'd16777219, 1'b0, 8'd0);   // tie, rounds up
      send_decimal(96'd33554431, 1'b0, 8'd0);   // rounding carries into exponent
      send_decimal(96'd1, 1'b0, 8'd1);
      send_decimal(96'd123456789, 1'b1, 8'd9);
      send_decimal({32'hffffffff, 64'h0}, 1'b0, 8'd14);
      send_decimal(96'd5, 1'b0, 8'd1);
      send_decimal(96'h800000000000000000000000, 1'b1, 8'd27);
      // random decimals, occasionally with a rejected scale
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         m = rand_mant();
         s = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(29, 255))
                                         : 8'($urandom_range(0, 28));
         send_decimal(m, 1'($urandom_range(0, 1)), s);
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
